// ===== rtl/rhpd_pkg.sv =====
// types and constants shared by the rtp h.264 payload depacketizer
// no dependencies

package rhpd_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
   localparam int unsigned RspDataW   = 24;

   localparam logic [4:0] TypeStapA  = 5'd24;
   localparam logic [4:0] TypeFuA    = 5'd28;
   localparam logic [4:0] TypeFuB    = 5'd29;
   localparam logic [4:0] TypeLastNal = 5'd23;
   localparam logic [4:0] TypeRsvdLo = 5'd30;
   localparam logic [7:0] TypeMask   = 8'h1F;
   localparam logic [7:0] NriMask    = 8'hE0;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SINGLE_BODY,
      PH_AGG_DON,
      PH_AGG_SIZE_HI,
      PH_AGG_SIZE_LO,
      PH_AGG_PREFIX,
      PH_AGG_HEADER,
      PH_AGG_BODY,
      PH_FU_HEADER,
      PH_FU_DON,
      PH_FU_BODY
   } phase_type;

   typedef enum logic [2:0] {
      KIND_STAP_A,
      KIND_STAP_B,
      KIND_MTAP16,
      KIND_MTAP24,
      KIND_FU_A,
      KIND_FU_B
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_ABORT,
      ST_RESERVED,
      ST_OVERRUN
   } status_type;

   typedef struct packed {
      status_type status;
      logic       nal_end;
      logic       nal_start;
      logic       has_byte;
      logic [7:0] out_byte;
      logic [7:0] nal_header;
   } rsp_item_type;

   function automatic rsp_item_type make_item(
      input logic [7:0] hdr,
      input logic [7:0] data,
      input logic       has,
      input logic       st,
      input logic       en,
      input status_type status
   );
      rsp_item_type item;
      item.nal_header = hdr;
      item.out_byte   = has ? data : 8'd0;
      item.has_byte   = has;
      item.nal_start  = st;
      item.nal_end    = en;
      item.status     = status;
      return item;
   endfunction

endpackage

// ===== rtl/rtp_h264_payload_depacketizer.sv =====
// rtp h.264 payload depacketizer: parser, input register and result queue
// depends on rhpd_pkg
//
// usage
// req channel: one rtp payload byte per word in req_tdata; req_tuser[0] marks the
//   first byte of a packet, req_tuser[1] flags packets lost before it, req_tlast
//   marks the last byte of a packet
// rsp channel: one result per word; a nal unit comes out as a start word with no
//   byte, then one word per body byte, rsp_tlast on its last word; rsp_tuser is
//   the status (ok, abort, reserved type, length overrun)
// single nal, stap-a/b, mtap16/24 and fu-a/b packets are handled; fragments are
//   joined into one unit with a rebuilt header
// an accepted byte is held in the input register, and its results are written into the result queue that drives rsp
// throughput: one byte per cycle while each byte gives at most one result and the
//   result queue has room; a byte that gives two results writes both into the
//   four-word result queue
// req_tready drops only when the result queue cannot take two more words, so a
//   stalled receiver backs up into the source after a few words
// reset clears the parser state, the input register and the result queue

module rtp_h264_payload_depacketizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // payload_byte
   input  logic        req_tlast,   // packet_last
   input  logic [1:0]  req_tuser,   // packet_first, loss_before
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // nal_header, out_byte, has_byte, nal_start, zero pad
   output logic        rsp_tlast,   // nal_end
   output logic [1:0]  rsp_tuser    // status
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   logic       in_loss_ff;

   // parser state
   rhpd_pkg::phase_type phase_ff, phase_in;
   rhpd_pkg::kind_type  kind_ff, kind_in;
   logic [2:0]  field_ff, field_in;
   logic [15:0] remain_ff, remain_in;
   logic [7:0]  len_hold_ff, len_hold_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  indicator_ff, indicator_in;
   logic        frag_open_ff, frag_open_in;

   // result queue
   rhpd_pkg::rsp_item_type queue_ff [rhpd_pkg::QueueDepth];
   logic [rhpd_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [rhpd_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rhpd_pkg::QueueCntW-1:0] count_ff, count_in;

   rhpd_pkg::rsp_item_type res [2];
   logic [1:0] nres;
   logic       advance;
   logic       pop;
   logic [rhpd_pkg::QueueCntW-1:0] push_n;
   rhpd_pkg::rsp_item_type head;

   assign advance    = in_valid_ff && (count_ff <= rhpd_pkg::QueueCntW'(rhpd_pkg::QueueDepth - 2));
   assign req_tready = !in_valid_ff || advance;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_n     = advance ? rhpd_pkg::QueueCntW'(nres) : '0;
   assign wr_ptr_next = wr_ptr_ff + rhpd_pkg::QueuePtrW'(1);

   // parser
   always_comb begin
      logic [4:0]  t;
      logic        is_fu;
      logic [7:0]  fu_hdr;
      logic        s_bit;
      logic        e_bit;
      logic        fin;
      logic [15:0] len;

      phase_in     = phase_ff;
      kind_in      = kind_ff;
      field_in     = field_ff;
      remain_in    = remain_ff;
      len_hold_in  = len_hold_ff;
      header_in    = header_ff;
      indicator_in = indicator_ff;
      frag_open_in = frag_open_ff;
      nres         = 2'd0;
      res[0]       = '0;
      res[1]       = '0;

      t      = in_byte_ff[4:0];
      is_fu  = (t == rhpd_pkg::TypeFuA) || (t == rhpd_pkg::TypeFuB);
      fu_hdr = (indicator_ff & rhpd_pkg::NriMask) | (in_byte_ff & rhpd_pkg::TypeMask);
      s_bit  = in_byte_ff[7];
      e_bit  = in_byte_ff[6];
      fin    = 1'b0;
      len    = {len_hold_ff, in_byte_ff};

      if (in_first_ff) begin
         if (phase_ff == rhpd_pkg::PH_SINGLE_BODY || phase_ff == rhpd_pkg::PH_AGG_BODY) begin
            res[nres[0]] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                               rhpd_pkg::ST_ABORT);
            nres = nres + 2'd1;
         end else if (frag_open_ff && (phase_ff == rhpd_pkg::PH_FU_DON ||
                                       phase_ff == rhpd_pkg::PH_FU_BODY)) begin
            res[nres[0]] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                               rhpd_pkg::ST_ABORT);
            nres = nres + 2'd1;
            frag_open_in = 1'b0;
         end
         if (frag_open_in && (in_loss_ff || !is_fu)) begin
            if (!nres[1]) begin
               res[nres[0]] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                                  rhpd_pkg::ST_ABORT);
               nres = nres + 2'd1;
            end
            frag_open_in = 1'b0;
         end
         phase_in = rhpd_pkg::PH_IDLE;

         if (t == 5'd0 || t >= rhpd_pkg::TypeRsvdLo) begin
            if (!nres[1]) begin
               res[nres[0]] = rhpd_pkg::make_item(in_byte_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                                  rhpd_pkg::ST_RESERVED);
               nres = nres + 2'd1;
            end
         end else if (t <= rhpd_pkg::TypeLastNal) begin
            header_in = in_byte_ff;
            if (!nres[1]) begin
               res[nres[0]] = rhpd_pkg::make_item(in_byte_ff, 8'd0, 1'b0, 1'b1, in_last_ff,
                                                  rhpd_pkg::ST_OK);
               nres = nres + 2'd1;
            end
            phase_in = in_last_ff ? rhpd_pkg::PH_IDLE : rhpd_pkg::PH_SINGLE_BODY;
         end else if (is_fu) begin
            kind_in      = (t == rhpd_pkg::TypeFuA) ? rhpd_pkg::KIND_FU_A : rhpd_pkg::KIND_FU_B;
            indicator_in = in_byte_ff;
            if (in_last_ff) begin
               if (!nres[1]) begin
                  res[nres[0]] = rhpd_pkg::make_item(in_byte_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                                     rhpd_pkg::ST_OVERRUN);
                  nres = nres + 2'd1;
               end
               frag_open_in = 1'b0;
            end else begin
               phase_in = rhpd_pkg::PH_FU_HEADER;
            end
         end else begin
            kind_in = rhpd_pkg::kind_type'({1'b0, t[1:0]});
            if (t == rhpd_pkg::TypeStapA) begin
               phase_in = rhpd_pkg::PH_AGG_SIZE_HI;
            end else begin
               field_in = 3'd2;
               phase_in = rhpd_pkg::PH_AGG_DON;
            end
            if (in_last_ff) begin
               phase_in = rhpd_pkg::PH_IDLE;
            end
         end
      end else if (phase_ff != rhpd_pkg::PH_IDLE) begin
         case (phase_ff)
            rhpd_pkg::PH_SINGLE_BODY: begin
               res[0] = rhpd_pkg::make_item(header_ff, in_byte_ff, 1'b1, 1'b0, in_last_ff,
                                            rhpd_pkg::ST_OK);
               nres = 2'd1;
            end
            rhpd_pkg::PH_AGG_DON: begin
               field_in = field_ff - 3'd1;
               if (field_in == 3'd0) begin
                  phase_in = rhpd_pkg::PH_AGG_SIZE_HI;
               end
            end
            rhpd_pkg::PH_AGG_SIZE_HI: begin
               len_hold_in = in_byte_ff;
               phase_in    = rhpd_pkg::PH_AGG_SIZE_LO;
            end
            rhpd_pkg::PH_AGG_SIZE_LO: begin
               if (len == 16'd0) begin
                  phase_in = rhpd_pkg::PH_AGG_SIZE_HI;
               end else begin
                  remain_in = len;
                  if (kind_ff == rhpd_pkg::KIND_MTAP16 || kind_ff == rhpd_pkg::KIND_MTAP24) begin
                     field_in = (kind_ff == rhpd_pkg::KIND_MTAP16) ? 3'd3 : 3'd4;
                     phase_in = rhpd_pkg::PH_AGG_PREFIX;
                  end else begin
                     phase_in = rhpd_pkg::PH_AGG_HEADER;
                  end
                  if (in_last_ff) begin
                     res[0] = rhpd_pkg::make_item(8'd0, 8'd0, 1'b0, 1'b0, 1'b0,
                                                  rhpd_pkg::ST_OVERRUN);
                     nres = 2'd1;
                  end
               end
            end
            rhpd_pkg::PH_AGG_PREFIX: begin
               field_in = field_ff - 3'd1;
               if (field_in == 3'd0) begin
                  phase_in = rhpd_pkg::PH_AGG_HEADER;
               end
               if (in_last_ff) begin
                  res[0] = rhpd_pkg::make_item(8'd0, 8'd0, 1'b0, 1'b0, 1'b0,
                                               rhpd_pkg::ST_OVERRUN);
                  nres = 2'd1;
               end
            end
            rhpd_pkg::PH_AGG_HEADER: begin
               header_in = in_byte_ff;
               remain_in = remain_ff - 16'd1;
               fin       = (remain_in == 16'd0);
               res[0] = rhpd_pkg::make_item(in_byte_ff, 8'd0, 1'b0, 1'b1, fin,
                                            rhpd_pkg::ST_OK);
               nres = 2'd1;
               phase_in = fin ? rhpd_pkg::PH_AGG_SIZE_HI : rhpd_pkg::PH_AGG_BODY;
               if (in_last_ff && !fin) begin
                  res[1] = rhpd_pkg::make_item(in_byte_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                               rhpd_pkg::ST_OVERRUN);
                  nres = 2'd2;
               end
            end
            rhpd_pkg::PH_AGG_BODY: begin
               remain_in = remain_ff - 16'd1;
               fin       = (remain_in == 16'd0);
               res[0] = rhpd_pkg::make_item(header_ff, in_byte_ff, 1'b1, 1'b0, fin,
                                            rhpd_pkg::ST_OK);
               nres = 2'd1;
               if (fin) begin
                  phase_in = rhpd_pkg::PH_AGG_SIZE_HI;
               end
               if (in_last_ff && !fin) begin
                  res[1] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                               rhpd_pkg::ST_OVERRUN);
                  nres = 2'd2;
               end
            end
            rhpd_pkg::PH_FU_HEADER: begin
               if (s_bit) begin
                  if (frag_open_ff) begin
                     res[nres[0]] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b0,
                                                        rhpd_pkg::ST_ABORT);
                     nres = nres + 2'd1;
                  end
                  header_in    = fu_hdr;
                  frag_open_in = !(e_bit && in_last_ff);
                  res[nres[0]] = rhpd_pkg::make_item(fu_hdr, 8'd0, 1'b0, 1'b1,
                                                     e_bit && in_last_ff, rhpd_pkg::ST_OK);
                  nres = nres + 2'd1;
               end else if (!frag_open_ff) begin
                  res[0] = rhpd_pkg::make_item(fu_hdr, 8'd0, 1'b0, 1'b0, 1'b0,
                                               rhpd_pkg::ST_ABORT);
                  nres = 2'd1;
               end else if (e_bit && in_last_ff) begin
                  res[0] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b1,
                                               rhpd_pkg::ST_OK);
                  nres = 2'd1;
                  frag_open_in = 1'b0;
               end
               if (s_bit || frag_open_ff) begin
                  field_in = {e_bit, kind_ff == rhpd_pkg::KIND_FU_B, 1'b0};
                  phase_in = (field_in[1:0] != 2'd0) ? rhpd_pkg::PH_FU_DON : rhpd_pkg::PH_FU_BODY;
               end else begin
                  phase_in = rhpd_pkg::PH_IDLE;
               end
            end
            rhpd_pkg::PH_FU_DON: begin
               field_in = {field_ff[2], field_ff[1:0] - 2'd1};
               if (field_in[1:0] == 2'd0) begin
                  phase_in = rhpd_pkg::PH_FU_BODY;
               end
               if (in_last_ff && field_ff[2] && frag_open_ff) begin
                  res[0] = rhpd_pkg::make_item(header_ff, 8'd0, 1'b0, 1'b0, 1'b1,
                                               rhpd_pkg::ST_OK);
                  nres = 2'd1;
                  frag_open_in = 1'b0;
               end
            end
            rhpd_pkg::PH_FU_BODY: begin
               fin = in_last_ff && field_ff[2];
               res[0] = rhpd_pkg::make_item(header_ff, in_byte_ff, 1'b1, 1'b0, fin,
                                            rhpd_pkg::ST_OK);
               nres = 2'd1;
               if (fin) begin
                  frag_open_in = 1'b0;
               end
            end
            default: begin
               phase_in = rhpd_pkg::PH_IDLE;
            end
         endcase
         if (in_last_ff) begin
            phase_in = rhpd_pkg::PH_IDLE;
         end
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + rhpd_pkg::QueuePtrW'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + rhpd_pkg::QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - (pop ? rhpd_pkg::QueueCntW'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= rhpd_pkg::PH_IDLE;
         kind_ff      <= rhpd_pkg::KIND_STAP_A;
         field_ff     <= 3'd0;
         remain_ff    <= 16'd0;
         len_hold_ff  <= 8'd0;
         header_ff    <= 8'd0;
         indicator_ff <= 8'd0;
         frag_open_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            kind_ff      <= kind_in;
            field_ff     <= field_in;
            remain_ff    <= remain_in;
            len_hold_ff  <= len_hold_in;
            header_ff    <= header_in;
            indicator_ff <= indicator_in;
            frag_open_ff <= frag_open_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
         in_loss_ff  <= req_tuser[1];
      end
      if (advance && nres != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res[0];
      end
      if (advance && nres[1]) begin
         queue_ff[wr_ptr_next] <= res[1];
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {6'd0, head.nal_start, head.has_byte, head.out_byte, head.nal_header};
   assign rsp_tlast  = head.nal_end;
   assign rsp_tuser  = head.status;

endmodule

// ===== rtl/rhpd_checker.sv =====
// port-level checks for the rtp h.264 payload depacketizer, bound to the top level
// depends on rhpd_pkg and rtp_h264_payload_depacketizer

module rhpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
   else $error("rsp word changed while stalled");

   // error words carry no byte and no unit marks
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rhpd_pkg::ST_OK |->
         rsp_tdata[17:8] == 10'd0 && !rsp_tlast)
   else $error("error word with byte or marks");

   // a start word never carries a body byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[16] && rsp_tdata[17]))
   else $error("start word with body byte");

   // queue is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
   else $error("rsp valid right after reset");

endmodule

bind rtp_h264_payload_depacketizer rhpd_checker u_rhpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/tb_rtp_h264_payload_depacketizer.sv =====
`timescale 1ns / 100ps
// self-checking bench for rtp_h264_payload_depacketizer: directed packets, then random
// single, aggregate, fragment, reserved and noise packets under source and sink throttling
// depends on rhpd_pkg and the depacketizer rtl

module tb_rtp_h264_payload_depacketizer;

   import rhpd_pkg::*;

   localparam logic [4:0] TypeReservedZero = 5'd0;
   localparam logic [4:0] TypeReservedTop  = 5'd31;
   localparam int unsigned RandomBytes = 600;

   typedef enum {
      CHECK_PREDICT,
      CHECK_NOTHING,
      CHECK_TYPED
   } row_check_type;

   typedef struct {
      logic [7:0]    data;
      bit            first;
      bit            last;
      row_check_type chk;
      rsp_item_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   // parser state mirrored by the predictor
   phase_type   dp_phase = PH_IDLE;
   kind_type    dp_kind = KIND_STAP_A;
   logic [2:0]  dp_fidx = 3'd0;
   logic [15:0] dp_remaining = 16'd0;
   logic [7:0]  dp_size_hi = 8'd0;
   logic [7:0]  dp_header = 8'd0;
   logic [7:0]  dp_indicator = 8'd0;
   logic        dp_frag_open = 1'b0;

   rsp_item_type step_words[$];
   rsp_item_type nal_words_due[$];
   stim_row_type stim_rows[$];
   int unsigned  mismatch_count = 0;
   int unsigned  src_idle_pct = 0;
   int unsigned  sink_stall_pct = 0;

   rtp_h264_payload_depacketizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic rsp_item_type make_word(logic [7:0] hdr, logic [7:0] body, bit has,
                                              bit st, bit en, status_type sts);
      rsp_item_type w;
      w.nal_header = hdr;
      w.out_byte   = has ? body : 8'd0;
      w.has_byte   = has;
      w.nal_start  = st;
      w.nal_end    = en;
      w.status     = sts;
      return w;
   endfunction

   function automatic void emit_word(logic [7:0] hdr, logic [7:0] body, bit has, bit st,
                                     bit en, status_type sts);
      if (step_words.size() < 2) step_words.push_back(make_word(hdr, body, has, st, en, sts));
   endfunction

   // returns 1 when the byte is taken by the parser, 0 when it is dropped while idle
   function automatic bit depacketize_byte(logic [7:0] b, bit first, bit last, bit loss);
      logic [4:0]  t;
      logic [7:0]  hdr;
      logic [15:0] len;
      bit          is_fu;
      bit          s;
      bit          e;
      bit          fin;
      bit          orphan;
      t = b[4:0];
      is_fu = (t == TypeFuA) || (t == TypeFuB);
      if (first) begin
         if (dp_phase == PH_SINGLE_BODY || dp_phase == PH_AGG_BODY) begin
            emit_word(dp_header, 8'd0, 0, 0, 0, ST_ABORT);
         end else if (dp_frag_open && (dp_phase == PH_FU_DON || dp_phase == PH_FU_BODY)) begin
            emit_word(dp_header, 8'd0, 0, 0, 0, ST_ABORT);
            dp_frag_open = 1'b0;
         end
         if (dp_frag_open && (loss || !is_fu)) begin
            emit_word(dp_header, 8'd0, 0, 0, 0, ST_ABORT);
            dp_frag_open = 1'b0;
         end
         dp_phase = PH_IDLE;
         if (t == TypeReservedZero || t >= TypeRsvdLo) begin
            emit_word(b, 8'd0, 0, 0, 0, ST_RESERVED);
         end else if (t <= TypeLastNal) begin
            dp_header = b;
            emit_word(b, 8'd0, 0, 1, last, ST_OK);
            dp_phase = last ? PH_IDLE : PH_SINGLE_BODY;
         end else if (is_fu) begin
            dp_kind = (t == TypeFuA) ? KIND_FU_A : KIND_FU_B;
            dp_indicator = b;
            if (last) begin
               emit_word(b, 8'd0, 0, 0, 0, ST_OVERRUN);
               dp_frag_open = 1'b0;
            end else begin
               dp_phase = PH_FU_HEADER;
            end
         end else begin
            dp_kind = kind_type'(t - TypeStapA);
            if (dp_kind == KIND_STAP_A) begin
               dp_phase = PH_AGG_SIZE_HI;
            end else begin
               dp_fidx = 3'd2;
               dp_phase = PH_AGG_DON;
            end
            if (last) dp_phase = PH_IDLE;
         end
         return 1'b1;
      end
      if (dp_phase == PH_IDLE) return 1'b0;
      case (dp_phase)
         PH_SINGLE_BODY: emit_word(dp_header, b, 1, 0, last, ST_OK);
         PH_AGG_DON: begin
            dp_fidx = dp_fidx - 3'd1;
            if (dp_fidx == 3'd0) dp_phase = PH_AGG_SIZE_HI;
         end
         PH_AGG_SIZE_HI: begin
            dp_size_hi = b;
            dp_phase = PH_AGG_SIZE_LO;
         end
         PH_AGG_SIZE_LO: begin
            len = {dp_size_hi, b};
            if (len == 16'd0) begin
               dp_phase = PH_AGG_SIZE_HI;
            end else begin
               dp_remaining = len;
               if (dp_kind == KIND_MTAP16 || dp_kind == KIND_MTAP24) begin
                  dp_fidx = (dp_kind == KIND_MTAP16) ? 3'd3 : 3'd4;
                  dp_phase = PH_AGG_PREFIX;
               end else begin
                  dp_phase = PH_AGG_HEADER;
               end
               if (last) emit_word(8'd0, 8'd0, 0, 0, 0, ST_OVERRUN);
            end
         end
         PH_AGG_PREFIX: begin
            dp_fidx = dp_fidx - 3'd1;
            if (dp_fidx == 3'd0) dp_phase = PH_AGG_HEADER;
            if (last) emit_word(8'd0, 8'd0, 0, 0, 0, ST_OVERRUN);
         end
         PH_AGG_HEADER: begin
            dp_header = b;
            dp_remaining = dp_remaining - 16'd1;
            fin = (dp_remaining == 16'd0);
            emit_word(b, 8'd0, 0, 1, fin, ST_OK);
            dp_phase = fin ? PH_AGG_SIZE_HI : PH_AGG_BODY;
            if (last && !fin) emit_word(dp_header, 8'd0, 0, 0, 0, ST_OVERRUN);
         end
         PH_AGG_BODY: begin
            dp_remaining = dp_remaining - 16'd1;
            fin = (dp_remaining == 16'd0);
            emit_word(dp_header, b, 1, 0, fin, ST_OK);
            if (fin) dp_phase = PH_AGG_SIZE_HI;
            if (last && !fin) emit_word(dp_header, 8'd0, 0, 0, 0, ST_OVERRUN);
         end
         PH_FU_HEADER: begin
            hdr = (dp_indicator & NriMask) | (b & TypeMask);
            s = b[7];
            e = b[6];
            orphan = !s && !dp_frag_open;
            if (s) begin
               if (dp_frag_open) emit_word(dp_header, 8'd0, 0, 0, 0, ST_ABORT);
               dp_header = hdr;
               dp_frag_open = !(e && last);
               emit_word(hdr, 8'd0, 0, 1, e && last, ST_OK);
            end else if (orphan) begin
               emit_word(hdr, 8'd0, 0, 0, 0, ST_ABORT);
               dp_phase = PH_IDLE;
            end else if (e && last) begin
               emit_word(dp_header, 8'd0, 0, 0, 1, ST_OK);
               dp_frag_open = 1'b0;
            end
            if (!orphan) begin
               dp_fidx = {e, dp_kind == KIND_FU_B, 1'b0};
               dp_phase = (dp_fidx[1:0] != 2'd0) ? PH_FU_DON : PH_FU_BODY;
            end
         end
         PH_FU_DON: begin
            e = dp_fidx[2];
            dp_fidx[1:0] = dp_fidx[1:0] - 2'd1;
            if (dp_fidx[1:0] == 2'd0) dp_phase = PH_FU_BODY;
            if (last && e && dp_frag_open) begin
               emit_word(dp_header, 8'd0, 0, 0, 1, ST_OK);
               dp_frag_open = 1'b0;
            end
         end
         PH_FU_BODY: begin
            e = last && dp_fidx[2];
            emit_word(dp_header, b, 1, 0, e, ST_OK);
            if (e) dp_frag_open = 1'b0;
         end
         default: dp_phase = PH_IDLE;
      endcase
      if (last) dp_phase = PH_IDLE;
      return 1'b1;
   endfunction

   function automatic void add_row(logic [7:0] data, bit first, bit last, row_check_type chk,
                                   logic [7:0] hdr = 8'd0, logic [7:0] body = 8'd0,
                                   bit has = 0, bit st = 0, bit en = 0,
                                   status_type sts = ST_OK);
      stim_row_type r;
      r.data  = data;
      r.first = first;
      r.last  = last;
      r.chk   = chk;
      r.want  = make_word(hdr, body, has, st, en, sts);
      stim_rows.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // drives one word, waits for the handshake, then queues what it should produce
   task automatic send_word(input logic [7:0] b, input bit first, input bit last,
                            input bit loss, input row_check_type chk,
                            input rsp_item_type want, output bit taken);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tuser  <= {loss, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_words.delete();
      taken = depacketize_byte(b, first, last, loss);
      if (chk == CHECK_PREDICT) begin
         foreach (step_words[i]) nal_words_due.push_back(step_words[i]);
      end else if (chk == CHECK_TYPED) begin
         nal_words_due.push_back(want);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (nal_words_due.size() == 0) begin
            $error("unexpected word: tdata %h tlast %b tuser %h", rsp_tdata, rsp_tlast,
                   rsp_tuser);
            mismatch_count++;
         end else begin
            want = nal_words_due.pop_front();
            check_field("nal_header", want.nal_header, rsp_tdata[7:0]);
            check_field("out_byte", want.out_byte, rsp_tdata[15:8]);
            check_field("has_byte", want.has_byte, rsp_tdata[16]);
            check_field("nal_start", want.nal_start, rsp_tdata[17]);
            check_field("nal_end", want.nal_end, rsp_tlast);
            check_field("status", want.status, rsp_tuser);
         end
      end
   end

   initial begin : stimulus
      rsp_item_type no_word;
      logic [7:0]   pkt[$];
      int unsigned  taken_total;
      int unsigned  choice;
      int unsigned  pkts;
      int unsigned  kind_sel;
      int unsigned  units;
      int unsigned  unit_size;
      int unsigned  body_n;
      int unsigned  cut;
      int unsigned  r;
      bit           fu_b;
      bit           noisy;
      bit           no_last;
      bit           taken;
      logic [4:0]   nal_type;

      taken_total = 0;
      no_word = make_word(8'd0, 8'd0, 0, 0, 0, ST_OK);

      // directed: idle bytes, reserved types, single unit extremes, fu corner cases, mtap16
      add_row(8'h5A, 0, 0, CHECK_NOTHING);
      add_row(8'h00, 1, 1, CHECK_TYPED, 8'h00, 8'h00, 0, 0, 0, ST_RESERVED);
      add_row(8'hFF, 1, 1, CHECK_TYPED, 8'hFF, 8'h00, 0, 0, 0, ST_RESERVED);
      add_row(8'h7E, 1, 0, CHECK_TYPED, 8'h7E, 8'h00, 0, 0, 0, ST_RESERVED);
      add_row(8'h33, 0, 1, CHECK_NOTHING);
      add_row(8'h65, 1, 0, CHECK_TYPED, 8'h65, 8'h00, 0, 1, 0, ST_OK);
      add_row(8'h00, 0, 0, CHECK_TYPED, 8'h65, 8'h00, 1, 0, 0, ST_OK);
      add_row(8'hFF, 0, 1, CHECK_TYPED, 8'h65, 8'hFF, 1, 0, 1, ST_OK);
      add_row(8'h01, 1, 1, CHECK_TYPED, 8'h01, 8'h00, 0, 1, 1, ST_OK);
      add_row(8'h7C, 1, 1, CHECK_TYPED, 8'h7C, 8'h00, 0, 0, 0, ST_OVERRUN);
      add_row(8'h7C, 1, 0, CHECK_NOTHING);
      add_row(8'h05, 0, 1, CHECK_TYPED, 8'h65, 8'h00, 0, 0, 0, ST_ABORT);
      add_row(8'h5C, 1, 0, CHECK_NOTHING);
      add_row(8'h87, 0, 0, CHECK_PREDICT);
      add_row(8'h12, 0, 0, CHECK_PREDICT);
      add_row(8'h01, 1, 1, CHECK_PREDICT);
      add_row(8'h1A, 1, 0, CHECK_PREDICT);
      add_row(8'hA5, 0, 0, CHECK_PREDICT);
      add_row(8'h5A, 0, 0, CHECK_PREDICT);
      add_row(8'h00, 0, 0, CHECK_PREDICT);
      add_row(8'h02, 0, 0, CHECK_PREDICT);
      add_row(8'h11, 0, 0, CHECK_PREDICT);
      add_row(8'h22, 0, 0, CHECK_PREDICT);
      add_row(8'h33, 0, 0, CHECK_PREDICT);
      add_row(8'h61, 0, 0, CHECK_PREDICT);
      add_row(8'h99, 0, 1, CHECK_PREDICT);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         send_word(stim_rows[i].data, stim_rows[i].first, stim_rows[i].last, 1'b0,
                   stim_rows[i].chk, stim_rows[i].want, taken);
      end

      while (taken_total < RandomBytes) begin
         case ((taken_total / 150) % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
            default: begin src_idle_pct = 22; sink_stall_pct = 22; end
         endcase
         choice = $urandom_range(99);
         pkts = (choice < 35) ? $urandom_range(2, 4) : 1;
         fu_b = $urandom_range(1);
         nal_type = $urandom_range(1, TypeLastNal);
         noisy = (choice >= 90);
         for (int p = 0; p < pkts; p++) begin
            pkt.delete();
            if (choice < 35) begin
               // fragmented unit spread over several packets
               pkt.push_back({3'($urandom_range(7)), fu_b ? TypeFuB : TypeFuA});
               pkt.push_back({p == 0, p == pkts - 1, $urandom_range(19) == 0, nal_type});
               if (fu_b) repeat (2) pkt.push_back($urandom_range(255));
               repeat ($urandom_range(0, 4)) pkt.push_back($urandom_range(255));
            end else if (choice < 55) begin
               pkt.push_back({3'($urandom_range(7)), nal_type});
               repeat ($urandom_range(0, 6)) pkt.push_back($urandom_range(255));
            end else if (choice < 85) begin
               kind_sel = $urandom_range(3);
               pkt.push_back({3'($urandom_range(7)), 5'(TypeStapA + kind_sel)});
               if (kind_sel != 0) repeat (2) pkt.push_back($urandom_range(255));
               units = $urandom_range(1, 3);
               repeat (units) begin
                  r = $urandom_range(19);
                  if (r == 0) unit_size = 0;
                  else if (r == 1) unit_size = $urandom_range(7, 65535);
                  else unit_size = $urandom_range(1, 6);
                  pkt.push_back(unit_size[15:8]);
                  pkt.push_back(unit_size[7:0]);
                  if (kind_sel >= 2) repeat (kind_sel + 1) pkt.push_back($urandom_range(255));
                  body_n = (unit_size > 6) ? $urandom_range(1, 6) : unit_size;
                  for (int k = 0; k < body_n; k++) begin
                     if (k == 0) pkt.push_back({3'($urandom_range(7)),
                                                5'($urandom_range(1, TypeLastNal))});
                     else pkt.push_back($urandom_range(255));
                  end
               end
            end else if (choice < 90) begin
               case ($urandom_range(2))
                  0: pkt.push_back({3'($urandom_range(7)), TypeReservedZero});
                  1: pkt.push_back({3'($urandom_range(7)), TypeRsvdLo});
                  default: pkt.push_back({3'($urandom_range(7)), TypeReservedTop});
               endcase
               repeat ($urandom_range(0, 3)) pkt.push_back($urandom_range(255));
            end else begin
               repeat ($urandom_range(1, 4)) pkt.push_back($urandom_range(255));
            end
            // broken packets: cut short or missing the last mark
            cut = pkt.size() - 1;
            r = $urandom_range(99);
            no_last = (r >= 8 && r < 12);
            if (r < 8) cut = $urandom_range(0, pkt.size() - 1);
            for (int i = 0; i <= cut; i++) begin
               if (noisy) begin
                  send_word(pkt[i], $urandom_range(1), $urandom_range(1), $urandom_range(1),
                            CHECK_PREDICT, no_word, taken);
               end else begin
                  send_word(pkt[i], i == 0, (i == cut) && !no_last,
                            (i == 0) && ($urandom_range(19) == 0), CHECK_PREDICT, no_word,
                            taken);
               end
               if (taken) taken_total++;
            end
         end
      end

      req_tvalid <= 1'b0;
      src_idle_pct = 0;
      sink_stall_pct = 0;
      while (nal_words_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
